>>> src/sensor_packet_plausibility_filter_defines.svh
// Assertion macros used by the plausibility filter core
`ifndef SENSOR_PACKET_PLAUSIBILITY_FILTER_DEFINES_SVH
`define SENSOR_PACKET_PLAUSIBILITY_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SPPF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SPPF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sppf_pkg.sv
// Types, constants and codes shared by the plausibility filter modules
`timescale 1ns / 1ps
`default_nettype none

package sppf_pkg;

  // Readings needed in a row before packets are accepted
  localparam int BASE_LEN = 4;
  localparam int GCNT_W   = $clog2(BASE_LEN + 1);
  localparam logic [GCNT_W-1:0] GCNT_FULL = GCNT_W'(BASE_LEN);
  localparam logic [GCNT_W-1:0] GCNT_LAST = GCNT_W'(BASE_LEN - 1);
  localparam logic [GCNT_W-1:0] GCNT_ONE  = GCNT_W'(1);

  // Plausible range, tenths of a degree
  localparam logic signed [11:0] TEMP_MIN = -12'sd500;
  localparam logic signed [11:0] TEMP_MAX = 12'sd500;
  localparam logic [7:0]         HUM_LIMIT = 8'd100;

  localparam int FLAGS_W     = 10;
  localparam int FLG_BADID   = 0;
  localparam int FLG_CHANNEL = 1;
  localparam int FLG_HUMID   = 2;
  localparam int FLG_RANGE   = 3;
  localparam int FLG_START   = 4;
  localparam int FLG_JUMP    = 5;
  localparam int FLG_READY   = 6;
  localparam int FLG_TIMEOUT = 7;
  localparam int FLG_RESET   = 8;
  localparam int FLG_BATTERY = 9;

  typedef enum logic [1:0] {
    MODE_PACKET = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_FETCH  = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_OWN_ID     = 3'd0,
    CFG_MAX_CHAN   = 3'd1,
    CFG_TEMP_CORR  = 3'd2,
    CFG_HUM_CHK    = 3'd3,
    CFG_JUMP_LIM   = 3'd4,
    CFG_SILENCE    = 3'd5,
    CFG_UPLOAD     = 3'd6,
    CFG_BATT_NOTE  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]        own_id;
    logic [2:0]        max_chan;
    logic signed [7:0] temp_corr;
    logic              hum_chk;
    logic [9:0]        jump_lim;
    logic [31:0]       silence_ms;
    logic [31:0]       upload_ms;
    logic [31:0]       batt_note_ms;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [31:0]        now_ms;
    logic [7:0]         packet_id;
    logic [2:0]         packet_channel;
    logic [7:0]         packet_humidity;
    logic signed [11:0] packet_temp;
    logic               battery_ok;
    logic [31:0]        packet_time_ms;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [FLAGS_W-1:0] status_flags;
    logic               upload_needed;
    logic signed [12:0] stored_temp;
    logic [7:0]         stored_humidity;
    logic [2:0]         stored_channel;
    logic               stored_battery_ok;
    logic [31:0]        stored_time_ms;
  } result_t;

endpackage

`default_nettype wire

>>> src/sppf_cfg.sv
// Configuration register file of the plausibility filter
`timescale 1ns / 1ps
`default_nettype none

module sppf_cfg
  import sppf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_OWN_ID:    cfg_nxt.own_id       = cfg_wdata[7:0];
        CFG_MAX_CHAN:  cfg_nxt.max_chan     = cfg_wdata[2:0];
        CFG_TEMP_CORR: cfg_nxt.temp_corr    = cfg_wdata[7:0];
        CFG_HUM_CHK:   cfg_nxt.hum_chk      = cfg_wdata[0];
        CFG_JUMP_LIM:  cfg_nxt.jump_lim     = cfg_wdata[9:0];
        CFG_SILENCE:   cfg_nxt.silence_ms   = cfg_wdata;
        CFG_UPLOAD:    cfg_nxt.upload_ms    = cfg_wdata;
        CFG_BATT_NOTE: cfg_nxt.batt_note_ms = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id       <= 8'd0;
      cfg_r.max_chan     <= 3'd4;
      cfg_r.temp_corr    <= 8'sd0;
      cfg_r.hum_chk      <= 1'b1;
      cfg_r.jump_lim     <= 10'd50;
      cfg_r.silence_ms   <= 32'd600000;
      cfg_r.upload_ms    <= 32'd600000;
      cfg_r.batt_note_ms <= 32'd86400000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> src/sppf_core.sv
// Sensor state and the step logic of the plausibility filter
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_packet_plausibility_filter_defines.svh"

module sppf_core
  import sppf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step_en,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output result_t    res
);

  logic signed [11:0] baseline_r, baseline_nxt;
  logic [GCNT_W-1:0]  good_count_r, good_count_nxt;
  logic [31:0]        last_good_r, last_good_nxt;
  logic [2:0]         seen_chan_r, seen_chan_nxt;
  logic [7:0]         seen_hum_r, seen_hum_nxt;
  logic [31:0]        batt_note_r, batt_note_nxt;
  logic               fresh_r, fresh_nxt;
  logic signed [12:0] kept_temp_r, kept_temp_nxt;
  logic [7:0]         kept_hum_r, kept_hum_nxt;
  logic [2:0]         kept_chan_r, kept_chan_nxt;
  logic               kept_batt_r, kept_batt_nxt;
  logic [31:0]        kept_time_r, kept_time_nxt;
  logic signed [12:0] up_temp_r, up_temp_nxt;
  logic [31:0]        up_time_r, up_time_nxt;

  logic signed [12:0] temp_diff;
  logic [12:0]        abs_diff;
  logic               jump_over;
  logic               in_range;
  logic signed [12:0] temp_sum;
  logic [31:0]        batt_elapsed;
  logic [31:0]        silence_elapsed;
  logic [31:0]        up_elapsed;
  logic [GCNT_W-1:0]  gc_base;
  logic               reject;
  logic               acc;
  logic [FLAGS_W-1:0] flags;
  logic               up_fresh;
  logic               upload;

  assign temp_diff = {baseline_r[11], baseline_r} - {item.packet_temp[11], item.packet_temp};
  assign abs_diff  = temp_diff[12] ? 13'(-temp_diff) : 13'(temp_diff);
  assign jump_over = abs_diff > {3'b000, cfg.jump_lim};
  assign in_range  = (item.packet_temp >= TEMP_MIN) && (item.packet_temp <= TEMP_MAX);
  assign temp_sum  = {item.packet_temp[11], item.packet_temp}
                   + {{5{cfg.temp_corr[7]}}, cfg.temp_corr};

  // Wrapping millisecond distances
  assign batt_elapsed    = item.now_ms - batt_note_r;
  assign silence_elapsed = item.now_ms - last_good_r;
  assign up_elapsed      = item.now_ms - up_time_r;

  always_comb begin
    baseline_nxt   = baseline_r;
    good_count_nxt = good_count_r;
    last_good_nxt  = last_good_r;
    seen_chan_nxt  = seen_chan_r;
    seen_hum_nxt   = seen_hum_r;
    batt_note_nxt  = batt_note_r;
    fresh_nxt      = fresh_r;
    kept_temp_nxt  = kept_temp_r;
    kept_hum_nxt   = kept_hum_r;
    kept_chan_nxt  = kept_chan_r;
    kept_batt_nxt  = kept_batt_r;
    kept_time_nxt  = kept_time_r;
    up_temp_nxt    = up_temp_r;
    up_time_nxt    = up_time_r;
    gc_base        = good_count_r;
    reject         = 1'b0;
    acc            = 1'b0;
    flags          = '0;

    unique case (item.mode)
      MODE_PACKET: begin
        if (item.packet_id != cfg.own_id) begin
          flags[FLG_BADID] = 1'b1;
        end else begin
          // Warn when a bad channel or humidity value differs from the last warned
          if (item.packet_channel > cfg.max_chan && item.packet_channel != seen_chan_r) begin
            flags[FLG_CHANNEL] = 1'b1;
            seen_chan_nxt      = item.packet_channel;
          end
          if (cfg.hum_chk && item.packet_humidity > HUM_LIMIT
              && item.packet_humidity != seen_hum_r) begin
            flags[FLG_HUMID] = 1'b1;
            seen_hum_nxt     = item.packet_humidity;
          end
          if (!in_range) begin
            flags[FLG_RANGE] = 1'b1;
          end else begin
            if (good_count_r == '0) begin
              flags[FLG_START] = 1'b1;
            end else if (jump_over) begin
              flags[FLG_JUMP] = 1'b1;
              // Drop the packet once the baseline is full, else restart it
              if (good_count_r >= GCNT_FULL) begin
                reject = 1'b1;
              end else begin
                gc_base = '0;
              end
            end
            if (!reject) begin
              baseline_nxt  = item.packet_temp;
              last_good_nxt = item.packet_time_ms;
              if (gc_base < GCNT_FULL) begin
                good_count_nxt = gc_base + GCNT_ONE;
                if (gc_base == GCNT_LAST) begin
                  acc              = 1'b1;
                  flags[FLG_READY] = 1'b1;
                end
              end else begin
                good_count_nxt = gc_base;
                acc            = 1'b1;
              end
            end
          end
        end
        if (acc) begin
          kept_temp_nxt = temp_sum;
          kept_hum_nxt  = item.packet_humidity;
          kept_chan_nxt = item.packet_channel;
          kept_batt_nxt = item.battery_ok;
          kept_time_nxt = item.packet_time_ms;
          fresh_nxt     = 1'b1;
          if (!item.battery_ok && batt_elapsed > cfg.batt_note_ms) begin
            flags[FLG_BATTERY] = 1'b1;
            batt_note_nxt      = item.now_ms;
          end
        end
      end
      MODE_TICK: begin
        if (last_good_r != '0 && silence_elapsed > cfg.silence_ms && good_count_r != '0) begin
          flags[FLG_TIMEOUT] = 1'b1;
          if (good_count_r > GCNT_ONE) begin
            good_count_nxt   = '0;
            flags[FLG_RESET] = 1'b1;
          end
          last_good_nxt = item.now_ms;
        end
      end
      MODE_FETCH: begin
        up_temp_nxt = kept_temp_r;
        up_time_nxt = kept_time_r;
        fresh_nxt   = 1'b0;
      end
      MODE_SPARE: begin
      end
      default: begin
      end
    endcase
  end

  // A fetch decides on the state before it clears the new-data mark
  assign up_fresh = (item.mode == MODE_FETCH) ? fresh_r : fresh_nxt;
  assign upload   = up_fresh && (up_time_r == '0 || kept_temp_nxt != up_temp_r
                                 || up_elapsed > cfg.upload_ms);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r   <= '0;
      good_count_r <= '0;
      last_good_r  <= '0;
      seen_chan_r  <= '0;
      seen_hum_r   <= '0;
      batt_note_r  <= '0;
      fresh_r      <= 1'b0;
      kept_temp_r  <= '0;
      kept_hum_r   <= '0;
      kept_chan_r  <= '0;
      kept_batt_r  <= 1'b0;
      kept_time_r  <= '0;
      up_temp_r    <= '0;
      up_time_r    <= '0;
    end else if (step_en) begin
      baseline_r   <= baseline_nxt;
      good_count_r <= good_count_nxt;
      last_good_r  <= last_good_nxt;
      seen_chan_r  <= seen_chan_nxt;
      seen_hum_r   <= seen_hum_nxt;
      batt_note_r  <= batt_note_nxt;
      fresh_r      <= fresh_nxt;
      kept_temp_r  <= kept_temp_nxt;
      kept_hum_r   <= kept_hum_nxt;
      kept_chan_r  <= kept_chan_nxt;
      kept_batt_r  <= kept_batt_nxt;
      kept_time_r  <= kept_time_nxt;
      up_temp_r    <= up_temp_nxt;
      up_time_r    <= up_time_nxt;
    end
  end

  assign res.accepted          = acc;
  assign res.status_flags      = flags;
  assign res.upload_needed     = upload;
  assign res.stored_temp       = kept_temp_nxt;
  assign res.stored_humidity   = kept_hum_nxt;
  assign res.stored_channel    = kept_chan_nxt;
  assign res.stored_battery_ok = kept_batt_nxt;
  assign res.stored_time_ms    = kept_time_nxt;

  `SPPF_ASSERT_IMP(a_acc_full_count, clk, rst_n, step_en && acc, item.mode == MODE_PACKET && good_count_nxt == GCNT_FULL, "accepted without a full baseline")
  `SPPF_ASSERT_IMP(a_reset_has_timeout, clk, rst_n, step_en && flags[FLG_RESET], flags[FLG_TIMEOUT], "baseline reset without timeout")
  `SPPF_ASSERT_NXT(a_fetch_clears, clk, rst_n, step_en && item.mode == MODE_FETCH, !fresh_r && up_time_r == $past(kept_time_r), "fetch did not take the kept reading")
  `SPPF_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, good_count_r <= GCNT_FULL, "good count beyond baseline length")

endmodule

`default_nettype wire

>>> src/sensor_packet_plausibility_filter.sv
// Top level of the sensor packet plausibility filter: stream registers around the core
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_tvalid/in_tready | in_tdata (96 b), in_tuser (mode)
//   out_    | out | out_tvalid/out_tready | out_tdata (72 b)
//   cfg_    | in  | cfg_we              | cfg_addr, cfg_wdata
//
// One transaction per cycle sustained while out_tready stays high; a result goes
// through the input and output registers. The sensor state loop sets the rate.
// Reset (rst_n low, synchronous) clears all sensor state and loads register defaults;
// no clearing pass follows. With out_tready low, an input register and an output
// register each hold a transaction before in_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module sensor_packet_plausibility_filter
  import sppf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // now_ms[31:0], packet_id[39:32], packet_channel[42:40], packet_humidity[50:43],
  // packet_temp[62:51], battery_ok[63], packet_time_ms[95:64]
  input  wire logic [95:0] in_tdata,
  // mode[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // accepted[0], status_flags[10:1], upload_needed[11], stored_temp[24:12],
  // stored_humidity[32:25], stored_channel[35:33], stored_battery_ok[36],
  // stored_time_ms[68:37], zero[71:69]
  output logic [71:0]      out_tdata
);

  cfg_t    cfg;
  item_t   in_item_r, in_item_nxt;
  logic    in_valid_r;
  result_t core_res;
  result_t out_res_r;
  logic    out_valid_r;
  logic    advance;

  sppf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_item_nxt.mode            = mode_t'(in_tuser);
  assign in_item_nxt.now_ms          = in_tdata[31:0];
  assign in_item_nxt.packet_id       = in_tdata[39:32];
  assign in_item_nxt.packet_channel  = in_tdata[42:40];
  assign in_item_nxt.packet_humidity = in_tdata[50:43];
  assign in_item_nxt.packet_temp     = in_tdata[62:51];
  assign in_item_nxt.battery_ok      = in_tdata[63];
  assign in_item_nxt.packet_time_ms  = in_tdata[95:64];

  // Step the held transaction whenever the output register is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_item_nxt;
    end
  end

  sppf_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       out_res_r.stored_time_ms,
                       out_res_r.stored_battery_ok,
                       out_res_r.stored_channel,
                       out_res_r.stored_humidity,
                       out_res_r.stored_temp,
                       out_res_r.upload_needed,
                       out_res_r.status_flags,
                       out_res_r.accepted};

endmodule

`default_nettype wire
